// ===== sv/sbp_pkg.sv =====
// shared types, codes and helpers for the split-read breakpoint pair block
package sbp_pkg;

  localparam int IN_TDATA_W = 120;
  localparam int IN_TUSER_W = 2;
  localparam int OUT_TDATA_W = 280;
  localparam int QUEUE_DEPTH_DEF = 4;
  localparam logic [7:0] QUAL_FLOOR_DEF = 8'd20;

  localparam logic CMD_HDR = 1'b0;
  localparam logic CMD_OP = 1'b1;

  localparam logic [3:0] OP_M = 4'd0;
  localparam logic [3:0] OP_I = 4'd1;
  localparam logic [3:0] OP_D = 4'd2;
  localparam logic [3:0] OP_N = 4'd3;
  localparam logic [3:0] OP_S = 4'd4;
  localparam logic [3:0] OP_H = 4'd5;

  // input tdata layout, lowest field last
  typedef struct packed {
    logic [27:0]        op_length;
    logic [3:0]         op_code;
    logic signed [16:0] edit_distance;
    logic [7:0]         mapping_quality;
    logic               reverse;
    logic [30:0]        ref_start;
    logic [30:0]        contig_id;
  } in_data_t;

  // classified item passed from front to back
  typedef struct packed {
    logic               is_hdr;
    logic               side;
    logic [30:0]        contig;
    logic [30:0]        ref_start;
    logic               reverse;
    logic [7:0]         quality;
    logic signed [16:0] edits;
    logic               is_clip;
    logic               add_q;
    logic               add_r;
    logic [27:0]        len;
    logic               last;
  } item_t;

  // final sums of a side at its last op
  typedef struct packed {
    logic        side;
    logic [27:0] lclip;
    logic [27:0] rclip;
    logic [31:0] qsum;
    logic [31:0] rsum;
  } close_t;

  typedef struct packed {
    logic [30:0]        contig;
    logic [31:0]        ref_lo;
    logic [31:0]        ref_hi;
    logic               reverse;
    logic [7:0]         quality;
    logic [31:0]        qlen;
    logic signed [16:0] edits;
    logic [27:0]        qstart;
  } side_rec_t;

  typedef struct packed {
    side_rec_t s1;
    side_rec_t s0;
  } pair_t;

  // output tdata layout, lowest field last
  typedef struct packed {
    logic [5:0]         pad;
    logic signed [31:0] query_gap;
    logic signed [16:0] second_edits;
    logic [31:0]        second_query_len;
    logic [7:0]         second_quality;
    logic [31:0]        second_ref_start;
    logic [30:0]        second_contig;
    logic signed [16:0] first_edits;
    logic [31:0]        first_query_len;
    logic [7:0]         first_quality;
    logic [1:0]         strand_pair;
    logic [31:0]        first_ref_end;
    logic [30:0]        first_contig;
  } out_rec_t;

  function automatic logic [31:0] sat_add32(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ===== sv/sbp_front.sv =====
// front end: accepts input transfers and classifies cigar ops
module sbp_front
  import sbp_pkg::*;
(
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic                  in_tlast,
  input  logic                  q_full,
  output logic                  q_push,
  output item_t                 q_item
);

  in_data_t d;

  assign d = in_tdata;
  assign in_tready = ~q_full;
  assign q_push = in_tvalid & ~q_full;

  always_comb begin
    q_item = '0;
    q_item.is_hdr = (in_tuser[0] == CMD_HDR);
    q_item.side = in_tuser[1];
    q_item.contig = d.contig_id;
    q_item.ref_start = d.ref_start;
    q_item.reverse = d.reverse;
    q_item.quality = d.mapping_quality;
    q_item.edits = d.edit_distance;
    q_item.len = d.op_length;
    q_item.last = in_tlast;
    unique case (d.op_code) inside
      OP_S, OP_H: q_item.is_clip = 1'b1;
      OP_M: begin
        q_item.add_q = 1'b1;
        q_item.add_r = 1'b1;
      end
      OP_I: q_item.add_q = 1'b1;
      OP_D, OP_N: q_item.add_r = 1'b1;
      default: ;
    endcase
  end

endmodule

// ===== sv/sbp_fifo.sv =====
// small register queue between front and back
module sbp_fifo
  import sbp_pkg::*;
#(
  parameter int W = $bits(item_t),
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] wdata,
  input  logic         pop,
  output logic [W-1:0] rdata,
  output logic         not_empty,
  output logic         full
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign rdata = mem_r[rd_ptr_r];
  assign not_empty = (count_r != '0);
  assign full = (count_r == CW'(DEPTH));

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== sv/sbp_accum.sv =====
// back end: per-side sums, side close and pair drop tracking
module sbp_accum
  import sbp_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  input  logic [7:0] cfg_data,
  input  logic       en,
  input  logic       q_valid,
  input  item_t      q_item,
  output logic       q_pop,
  output logic       emit_valid,
  output pair_t      emit_pair
);

  logic [7:0]         qual_floor_r;
  logic [30:0]        hdr_contig_r [2];
  logic [30:0]        hdr_start_r [2];
  logic [1:0]         hdr_rev_r;
  logic [7:0]         hdr_qual_r [2];
  logic signed [16:0] hdr_edits_r [2];
  logic [27:0]        qstart_r [2];
  logic [31:0]        ref_lo_r [2];
  logic [31:0]        ref_hi_r [2];
  logic [31:0]        qlen_r [2];
  logic [27:0]        lclip_r, rclip_r;
  logic [31:0]        qsum_r, rsum_r;
  logic               first_r;
  logic               dropped_r;
  logic               cls_valid_r;
  close_t             cls_r;

  logic        take;
  logic [27:0] lclip_nxt, rclip_nxt;
  logic [31:0] qsum_nxt, rsum_nxt;
  logic        cs;
  logic        close_go;
  logic        fail;
  logic [31:0] ref_end;
  logic [27:0] new_qstart;
  logic [31:0] new_lo, new_hi;

  assign take = en & q_valid;
  assign q_pop = take;

  // stage a: running sums
  always_comb begin
    lclip_nxt = (q_item.is_clip && first_r) ? q_item.len : lclip_r;
    rclip_nxt = (q_item.is_clip && !first_r) ? q_item.len : rclip_r;
    qsum_nxt = q_item.add_q ? sat_add32(qsum_r, {4'b0, q_item.len}) : qsum_r;
    rsum_nxt = q_item.add_r ? sat_add32(rsum_r, {4'b0, q_item.len}) : rsum_r;
  end

  // stage b: close a side
  always_comb begin
    cs = cls_r.side;
    close_go = en & cls_valid_r;
    fail = (hdr_qual_r[cs] < qual_floor_r) || (cls_r.lclip == '0 && cls_r.rclip == '0);
    ref_end = sat_add32({1'b0, hdr_start_r[cs]}, cls_r.rsum);
    if (hdr_rev_r[cs]) begin
      new_qstart = cls_r.rclip;
      new_lo = ref_end;
      new_hi = {1'b0, hdr_start_r[cs]};
    end else begin
      new_qstart = cls_r.lclip;
      new_lo = {1'b0, hdr_start_r[cs]};
      new_hi = ref_end;
    end
    emit_valid = close_go & cs & ~fail & ~dropped_r;
    emit_pair.s0.contig = hdr_contig_r[0];
    emit_pair.s0.ref_lo = ref_lo_r[0];
    emit_pair.s0.ref_hi = ref_hi_r[0];
    emit_pair.s0.reverse = hdr_rev_r[0];
    emit_pair.s0.quality = hdr_qual_r[0];
    emit_pair.s0.qlen = qlen_r[0];
    emit_pair.s0.edits = hdr_edits_r[0];
    emit_pair.s0.qstart = qstart_r[0];
    emit_pair.s1.contig = hdr_contig_r[1];
    emit_pair.s1.ref_lo = new_lo;
    emit_pair.s1.ref_hi = new_hi;
    emit_pair.s1.reverse = hdr_rev_r[1];
    emit_pair.s1.quality = hdr_qual_r[1];
    emit_pair.s1.qlen = cls_r.qsum;
    emit_pair.s1.edits = hdr_edits_r[1];
    emit_pair.s1.qstart = new_qstart;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qual_floor_r <= QUAL_FLOOR_DEF;
      for (int i = 0; i < 2; i++) begin
        hdr_contig_r[i] <= '0;
        hdr_start_r[i] <= '0;
        hdr_qual_r[i] <= '0;
        hdr_edits_r[i] <= '0;
        qstart_r[i] <= '0;
        ref_lo_r[i] <= '0;
        ref_hi_r[i] <= '0;
        qlen_r[i] <= '0;
      end
      hdr_rev_r <= '0;
      lclip_r <= '0;
      rclip_r <= '0;
      qsum_r <= '0;
      rsum_r <= '0;
      first_r <= 1'b1;
      dropped_r <= 1'b0;
      cls_valid_r <= 1'b0;
      cls_r <= '0;
    end else begin
      if (cfg_valid) begin
        qual_floor_r <= cfg_data;
      end
      if (close_go && !fail) begin
        qstart_r[cs] <= new_qstart;
        ref_lo_r[cs] <= new_lo;
        ref_hi_r[cs] <= new_hi;
        qlen_r[cs] <= cls_r.qsum;
      end
      // a new primary header starts a fresh pair
      if (take && q_item.is_hdr && !q_item.side) begin
        dropped_r <= 1'b0;
      end else if (close_go && fail) begin
        dropped_r <= 1'b1;
      end
      if (take) begin
        if (q_item.is_hdr) begin
          hdr_contig_r[q_item.side] <= q_item.contig;
          hdr_start_r[q_item.side] <= q_item.ref_start;
          hdr_rev_r[q_item.side] <= q_item.reverse;
          hdr_qual_r[q_item.side] <= q_item.quality;
          hdr_edits_r[q_item.side] <= q_item.edits;
        end
        if (q_item.is_hdr || q_item.last) begin
          lclip_r <= '0;
          rclip_r <= '0;
          qsum_r <= '0;
          rsum_r <= '0;
          first_r <= 1'b1;
        end else begin
          lclip_r <= lclip_nxt;
          rclip_r <= rclip_nxt;
          qsum_r <= qsum_nxt;
          rsum_r <= rsum_nxt;
          first_r <= 1'b0;
        end
        cls_r <= '{side: q_item.side, lclip: lclip_nxt, rclip: rclip_nxt,
                   qsum: qsum_nxt, rsum: rsum_nxt};
      end
      if (en) begin
        cls_valid_r <= take & ~q_item.is_hdr & q_item.last;
      end
    end
  end

endmodule

// ===== sv/sbp_emit.sv =====
// back end: orders the two sides, computes the gap and holds the record
module sbp_emit
  import sbp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   emit_valid,
  input  pair_t                  emit_pair,
  output logic                   en,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic        c_valid_r;
  pair_t       c_pair_r;
  logic        c_swap_r;
  logic [32:0] c_end0_r, c_end1_r;
  logic        out_tvalid_r;
  out_rec_t    out_rec_r;

  side_rec_t   a, b;
  logic [32:0] end_a;
  logic [33:0] diff;
  out_rec_t    rec_nxt;

  assign en = ~out_tvalid_r | out_tready;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata = out_rec_r;

  always_comb begin
    a = c_swap_r ? c_pair_r.s1 : c_pair_r.s0;
    b = c_swap_r ? c_pair_r.s0 : c_pair_r.s1;
    end_a = c_swap_r ? c_end1_r : c_end0_r;
    diff = {6'b0, b.qstart} - {1'b0, end_a};
    rec_nxt = '0;
    rec_nxt.first_contig = a.contig;
    rec_nxt.first_ref_end = a.ref_hi;
    rec_nxt.strand_pair = {b.reverse, a.reverse};
    rec_nxt.first_quality = a.quality;
    rec_nxt.first_query_len = a.qlen;
    rec_nxt.first_edits = a.edits;
    rec_nxt.second_contig = b.contig;
    rec_nxt.second_ref_start = b.ref_lo;
    rec_nxt.second_quality = b.quality;
    rec_nxt.second_query_len = b.qlen;
    rec_nxt.second_edits = b.edits;
    // only the low end can overflow
    if (diff[33] && diff[33:31] != 3'b111) begin
      rec_nxt.query_gap = 32'sh8000_0000;
    end else begin
      rec_nxt.query_gap = diff[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_valid_r <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else if (en) begin
      c_valid_r <= emit_valid;
      out_tvalid_r <= c_valid_r;
    end
    if (en) begin
      c_pair_r <= emit_pair;
      c_swap_r <= emit_pair.s0.qstart > emit_pair.s1.qstart;
      c_end0_r <= {5'b0, emit_pair.s0.qstart} + {1'b0, emit_pair.s0.qlen};
      c_end1_r <= {5'b0, emit_pair.s1.qstart} + {1'b0, emit_pair.s1.qlen};
      out_rec_r <= rec_nxt;
    end
  end

endmodule

// ===== sv/split_read_breakpoint_pair_core.sv =====
// top level of the split-read breakpoint pair block
//
// channel  dir  handshake            payload
// in_      in   in_tvalid/in_tready  tdata 120b, tuser {side, cmd}, tlast last op
// out_     out  out_tvalid/tready    tdata 280b breakpoint record
// cfg_     in   cfg_valid/cfg_ready  cfg_data min mapping quality
//
// one input transfer per cycle while the back end advances
// a record shows on out_tvalid after the closing op transfer passes the queue,
// cls_valid_r, then c_valid_r and out_tvalid_r; items waiting in the queue delay it
// further; a stalled output holds the back end, the queue then takes up to its depth
// synchronous active-low reset; no clearing pass, ready the cycle after reset
module split_read_breakpoint_pair_core
  import sbp_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // contig_id, ref_start, reverse, mapping_quality, edit_distance, op_code, op_length
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // cmd, side
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // first_contig, first_ref_end, strand_pair, first_quality, first_query_len,
  // first_edits, second_contig, second_ref_start, second_quality,
  // second_query_len, second_edits, query_gap, zero pad
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [7:0]             cfg_data
);

  item_t push_item;
  item_t pop_item;
  logic  q_push;
  logic  q_pop;
  logic  q_full;
  logic  q_valid;
  logic  en;
  logic  emit_valid;
  pair_t emit_pair;

  assign cfg_ready = 1'b1;

  sbp_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_item    (push_item)
  );

  sbp_fifo #(
    .W     ($bits(item_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (push_item),
    .pop       (q_pop),
    .rdata     (pop_item),
    .not_empty (q_valid),
    .full      (q_full)
  );

  sbp_accum u_accum (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .en         (en),
    .q_valid    (q_valid),
    .q_item     (pop_item),
    .q_pop      (q_pop),
    .emit_valid (emit_valid),
    .emit_pair  (emit_pair)
  );

  sbp_emit u_emit (
    .clk        (clk),
    .rst_n      (rst_n),
    .emit_valid (emit_valid),
    .emit_pair  (emit_pair),
    .en         (en),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

// ===== sv/sbp_checker.sv =====
// port-level checks for the split-read breakpoint pair block
module sbp_checker
  import sbp_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  // stalled record holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("record changed while stalled");

  // the queue only fills while the output is stalled
  a_in_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> $past(out_tvalid && !out_tready))
    else $error("input blocked without output stall");

  // a positive gap is bounded by a 28-bit clip
  a_gap_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[273] || out_tdata[272:270] == 3'b000))
    else $error("query gap out of range");

endmodule

bind split_read_breakpoint_pair_core sbp_checker u_sbp_checker (.*);
